[design/fuzzy_subsequence_command_match_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the command matcher
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef FUZZY_SUBSEQUENCE_COMMAND_MATCH_DEFINES_SVH
`define FUZZY_SUBSEQUENCE_COMMAND_MATCH_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FSCM_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSCM_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FSCM_ASSERT_IMP(label, ck, rn, ante, cons, msg)
`define FSCM_ASSERT_NXT(label, ck, rn, ante, cons, msg)

`endif

`endif

[design/fscm_pkg.sv]
// ----------------------------------------------------------------------------
// fscm_pkg
// Beat types, request codes and helpers for the command matcher.
// ----------------------------------------------------------------------------
package fscm_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned NAME_CHARS_DEF  = 39;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_NAME  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_END   = 2'd3;

  localparam logic RESP_ADD   = 1'b0;
  localparam logic RESP_QUERY = 1'b1;

  localparam logic signed [31:0] BEST_NONE = -32'sd1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         char_code;
    logic               is_last;
    logic signed [31:0] command_id;
  } in_item_t;

  typedef struct packed {
    logic               resp_kind;
    logic               add_ok;
    logic [5:0]         entry_index;
    logic [6:0]         match_count;
    logic               best_found;
    logic signed [31:0] best_id;
  } out_item_t;

  // fold ASCII upper case to lower case
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

[design/fuzzy_subsequence_command_match.sv]
// ----------------------------------------------------------------------------
// fuzzy_subsequence_command_match
// Command table with case-insensitive subsequence search over stored names.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Clear and name beats
// never raise busy; a name beat that is the last one of its name returns
// its add reply on the next cycle. A nonzero query byte, when the table
// holds entries, keeps busy high while a single shared name-byte read port
// walks the table, comparing the name bytes of each live entry in turn. End
// of query walks any stored entries and then shows the reply. Each reply is
// on out_data for one cycle under out_valid and cannot be held off. After
// reset the table is empty; no clearing pass is needed.
`include "fuzzy_subsequence_command_match_defines.svh"

module fuzzy_subsequence_command_match #(
  parameter int unsigned MAX_ENTRIES = fscm_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned NAME_CHARS  = fscm_pkg::NAME_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fscm_pkg::in_item_t  in_data,
  output logic                out_valid,
  output fscm_pkg::out_item_t out_data
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned PW    = $clog2(NAME_CHARS + 1);
  localparam int unsigned CHARS = MAX_ENTRIES * NAME_CHARS;
  localparam int unsigned AW    = (CHARS > 1) ? $clog2(CHARS) : 1;
  localparam int unsigned BW    = $clog2(CHARS + 1);

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ENTRIES);
  localparam logic [PW-1:0]    NC_P  = PW'(NAME_CHARS);
  localparam logic [BW-1:0]    NC_B  = BW'(NAME_CHARS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_LOAD,
    ST_SCAN_CMP,
    ST_END_LOAD
  } state_t;

  typedef struct packed {
    logic          failed;
    logic [PW-1:0] pos;
  } scan_st_t;

  // memories
  logic [7:0]         name_mem  [CHARS];
  logic [PW-1:0]      len_mem   [MAX_ENTRIES];
  logic signed [31:0] ident_mem [MAX_ENTRIES];
  scan_st_t           scan_mem  [MAX_ENTRIES];

  logic [7:0]         ch_q;
  logic [PW-1:0]      len_q;
  logic signed [31:0] id_q;
  scan_st_t           st_q;

  logic          name_we;
  logic [AW-1:0] name_waddr;
  logic          ent_we;
  logic [PW-1:0] ent_len;
  logic          st_we;
  scan_st_t      st_wdata;

  // control registers
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    entry_count_r, entry_count_nxt;
  logic [BW-1:0]       wbase_r, wbase_nxt;
  logic [PW-1:0]       wpos_r, wpos_nxt;
  logic                closed_r, closed_nxt;
  logic [MAX_ENTRIES-1:0] qvalid_r, qvalid_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [BW-1:0]       base_r, base_nxt;
  logic [AW-1:0]       char_addr_r, char_addr_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [PW-1:0]       len_r, len_nxt;
  logic [7:0]          q_char_r, q_char_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                found_r, found_nxt;
  logic signed [31:0]  best_r, best_nxt;
  logic                out_valid_r, out_valid_nxt;
  fscm_pkg::out_item_t out_data_r, out_data_nxt;

  logic accept;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic             closed_v;
    logic [PW-1:0]    wpos_inc;
    logic [PW-1:0]    st_pos;
    logic             st_fail;
    logic [PW-1:0]    len_v;
    logic             step_entry;
    logic             last_entry;
    logic             matched;
    logic [CNT_W-1:0] cnt_v;
    logic             found_v;
    logic signed [31:0] best_v;

    state_nxt       = state_r;
    entry_count_nxt = entry_count_r;
    wbase_nxt       = wbase_r;
    wpos_nxt        = wpos_r;
    closed_nxt      = closed_r;
    qvalid_nxt      = qvalid_r;
    idx_nxt         = idx_r;
    base_nxt        = base_r;
    char_addr_nxt   = char_addr_r;
    pos_nxt         = pos_r;
    len_nxt         = len_r;
    q_char_nxt      = q_char_r;
    cnt_nxt         = cnt_r;
    found_nxt       = found_r;
    best_nxt        = best_r;
    out_valid_nxt   = 1'b0;
    out_data_nxt    = out_data_r;

    name_we    = 1'b0;
    name_waddr = AW'(wbase_r + BW'(wpos_r));
    ent_we     = 1'b0;
    ent_len    = wpos_r;
    st_we      = 1'b0;
    st_wdata   = '0;

    closed_v   = closed_r || (in_data.char_code == 8'd0);
    wpos_inc   = wpos_r;
    st_pos     = qvalid_r[idx_r] ? st_q.pos : '0;
    st_fail    = qvalid_r[idx_r] && st_q.failed;
    len_v      = (len_q > NC_P) ? NC_P : len_q;
    step_entry = 1'b0;
    last_entry = ((CNT_W'(idx_r) + CNT_W'(1)) == entry_count_r);
    matched    = !st_fail;
    cnt_v      = cnt_r + CNT_W'(matched);
    found_v    = found_r || matched;
    best_v     = (matched && !found_r) ? id_q : best_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.req_type)
            fscm_pkg::REQ_CLEAR: begin
              entry_count_nxt = '0;
              wbase_nxt       = '0;
              wpos_nxt        = '0;
              closed_nxt      = 1'b0;
              qvalid_nxt      = '0;
            end
            fscm_pkg::REQ_NAME: begin
              qvalid_nxt = '0;
              if (!closed_v && entry_count_r < MAX_C && wpos_r < NC_P) begin
                name_we  = 1'b1;
                wpos_inc = wpos_r + PW'(1);
              end
              if (in_data.is_last) begin
                out_valid_nxt                = 1'b1;
                out_data_nxt.resp_kind       = fscm_pkg::RESP_ADD;
                out_data_nxt.match_count     = '0;
                out_data_nxt.best_found      = 1'b0;
                out_data_nxt.best_id         = '0;
                if (entry_count_r < MAX_C) begin
                  ent_we                   = 1'b1;
                  ent_len                  = wpos_inc;
                  out_data_nxt.add_ok      = 1'b1;
                  out_data_nxt.entry_index = 6'(entry_count_r);
                  entry_count_nxt          = entry_count_r + CNT_W'(1);
                  wbase_nxt                = wbase_r + NC_B;
                end else begin
                  out_data_nxt.add_ok      = 1'b0;
                  out_data_nxt.entry_index = '0;
                end
                wpos_nxt   = '0;
                closed_nxt = 1'b0;
              end else begin
                wpos_nxt   = wpos_inc;
                closed_nxt = closed_v;
              end
            end
            fscm_pkg::REQ_QUERY: begin
              // a zero byte in a query is dropped
              if (in_data.char_code != 8'd0 && entry_count_r != '0) begin
                q_char_nxt = fscm_pkg::fold_char(in_data.char_code);
                idx_nxt    = '0;
                base_nxt   = '0;
                state_nxt  = ST_SCAN_LOAD;
              end
            end
            fscm_pkg::REQ_END: begin
              if (entry_count_r == '0) begin
                out_valid_nxt            = 1'b1;
                out_data_nxt.resp_kind   = fscm_pkg::RESP_QUERY;
                out_data_nxt.add_ok      = 1'b0;
                out_data_nxt.entry_index = '0;
                out_data_nxt.match_count = '0;
                out_data_nxt.best_found  = 1'b0;
                out_data_nxt.best_id     = fscm_pkg::BEST_NONE;
                qvalid_nxt               = '0;
              end else begin
                idx_nxt   = '0;
                cnt_nxt   = '0;
                found_nxt = 1'b0;
                best_nxt  = fscm_pkg::BEST_NONE;
                state_nxt = ST_END_LOAD;
              end
            end
          endcase
        end
      end

      ST_SCAN_LOAD: begin
        if (st_fail) begin
          step_entry = 1'b1;
        end else if (st_pos >= len_v) begin
          st_we      = 1'b1;
          st_wdata   = '{failed: 1'b1, pos: len_v};
          step_entry = 1'b1;
        end else begin
          pos_nxt       = st_pos;
          len_nxt       = len_v;
          char_addr_nxt = AW'(base_r + BW'(st_pos));
          state_nxt     = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        if (fscm_pkg::fold_char(ch_q) == q_char_r) begin
          st_we      = 1'b1;
          st_wdata   = '{failed: 1'b0, pos: pos_r + PW'(1)};
          step_entry = 1'b1;
        end else if ((pos_r + PW'(1)) >= len_r) begin
          st_we      = 1'b1;
          st_wdata   = '{failed: 1'b1, pos: len_r};
          step_entry = 1'b1;
        end else begin
          // advance to the next name byte
          pos_nxt       = pos_r + PW'(1);
          char_addr_nxt = char_addr_r + AW'(1);
        end
      end

      ST_END_LOAD: begin
        cnt_nxt   = cnt_v;
        found_nxt = found_v;
        best_nxt  = best_v;
        if (last_entry) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.resp_kind   = fscm_pkg::RESP_QUERY;
          out_data_nxt.add_ok      = 1'b0;
          out_data_nxt.entry_index = '0;
          out_data_nxt.match_count = 7'(cnt_v);
          out_data_nxt.best_found  = found_v;
          out_data_nxt.best_id     = best_v;
          qvalid_nxt               = '0;
          state_nxt                = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
    endcase

    if (st_we) begin
      qvalid_nxt[idx_r] = 1'b1;
    end

    if (step_entry) begin
      if (last_entry) begin
        state_nxt = ST_IDLE;
      end else begin
        idx_nxt   = idx_r + IDX_W'(1);
        base_nxt  = base_r + NC_B;
        state_nxt = ST_SCAN_LOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
      wbase_r       <= '0;
      wpos_r        <= '0;
      closed_r      <= 1'b0;
      qvalid_r      <= '0;
      idx_r         <= '0;
      base_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      wbase_r       <= wbase_nxt;
      wpos_r        <= wpos_nxt;
      closed_r      <= closed_nxt;
      qvalid_r      <= qvalid_nxt;
      idx_r         <= idx_nxt;
      base_r        <= base_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    char_addr_r <= char_addr_nxt;
    pos_r       <= pos_nxt;
    len_r       <= len_nxt;
    q_char_r    <= q_char_nxt;
    cnt_r       <= cnt_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    out_data_r  <= out_data_nxt;
  end

  // name byte store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (name_we) begin
      name_mem[name_waddr] <= in_data.char_code;
    end
    ch_q <= name_mem[char_addr_nxt];
  end

  // per-entry length and identifier
  always_ff @(posedge clk) begin
    if (ent_we) begin
      len_mem[entry_count_r[IDX_W-1:0]]   <= ent_len;
      ident_mem[entry_count_r[IDX_W-1:0]] <= in_data.command_id;
    end
    len_q <= len_mem[idx_nxt];
    id_q  <= ident_mem[idx_nxt];
  end

  // per-entry scan position and failed flag; qvalid_r masks stale entries
  always_ff @(posedge clk) begin
    if (st_we) begin
      scan_mem[idx_r] <= st_wdata;
    end
    st_q <= scan_mem[idx_nxt];
  end

  `FSCM_ASSERT_IMP(a_wpos_range, clk, rst_n, 1'b1, wpos_r <= NC_P,
    "name write position beyond name size")
  `FSCM_ASSERT_NXT(a_busy_holds_table, clk, rst_n, busy, $stable(entry_count_r),
    "table size changed during a scan")
  `FSCM_ASSERT_IMP(a_cmp_in_name, clk, rst_n, state_r == ST_SCAN_CMP, pos_r < len_r,
    "compare past the end of a name")
  `FSCM_ASSERT_IMP(a_scan_live_entry, clk, rst_n,
    (state_r == ST_SCAN_LOAD) || (state_r == ST_END_LOAD),
    CNT_W'(idx_r) < entry_count_r, "scan index beyond stored entries")
  `FSCM_ASSERT_IMP(a_out_source, clk, rst_n, out_valid_r,
    $past(accept) || $past(state_r == ST_END_LOAD), "reply beat without a cause")

endmodule

[verif/fuzzy_subsequence_command_match_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_subsequence_command_match_tb
// Self-checking bench for the command matcher. A driver sends name, query,
// end and clear beats from a queue with random gaps. A monitor checks every
// reply against a predictor of the command table that runs on each accepted
// beat.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_command_match_tb;
  import fscm_pkg::*;

  localparam int ENTRIES      = MAX_ENTRIES_DEF;
  localparam int NAME_LEN     = NAME_CHARS_DEF;
  localparam int DIRECTED     = 23;
  localparam int RANDOM_BEATS = 207;
  localparam int TAIL_CYCLES  = 3000;
  localparam logic [31:0] BOUNDARY_BYTES = {8'h40, 8'h5B, 8'h60, 8'h7B};

  typedef struct packed {
    in_item_t beat;
    logic     drain;
  } pending_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  fuzzy_subsequence_command_match uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predicted table and query state
  logic [7:0]        name_mem [0:ENTRIES-1][0:NAME_LEN-1];
  logic [5:0]        name_len [0:ENTRIES-1];
  logic signed [31:0] ident   [0:ENTRIES-1];
  logic [6:0]        n_entries = '0;
  logic [5:0]        wr_pos = '0;
  logic [5:0]        scan_pos [0:ENTRIES-1];
  bit                failed   [0:ENTRIES-1];
  bit                closed = 1'b0;

  // stimulus-side copy of stored names, used to shape matching queries
  logic [7:0] gen_name [0:ENTRIES-1][0:NAME_LEN-1];
  int         gen_len  [0:ENTRIES-1];
  int         gen_cnt = 0;

  pending_t  beats_to_send [$];
  out_item_t replies_due [$];
  out_item_t new_reply;
  out_item_t oldest_reply;
  pending_t  next_beat;
  int        idle_left = 0;
  int        beat_count = 0;
  int        err_count = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c | 8'h20;
    return r;
  endfunction

  function automatic void reset_scan();
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      scan_pos[i] = '0;
      failed[i] = 1'b0;
    end
  endfunction

  // Apply one accepted beat to the table; return 1 when it yields a reply.
  function automatic bit predict_reply(input in_item_t b, output out_item_t r);
    int i;
    int pos;
    int len;
    logic [7:0] q;
    r = '0;
    case (b.req_type)
      REQ_CLEAR: begin
        n_entries = '0;
        wr_pos = '0;
        closed = 1'b0;
        reset_scan();
        return 1'b0;
      end
      REQ_NAME: begin
        reset_scan();
        if (b.char_code == 8'h00) closed = 1'b1;
        if (!closed && n_entries < ENTRIES && wr_pos < NAME_LEN) begin
          name_mem[n_entries][wr_pos] = b.char_code;
          wr_pos = wr_pos + 6'd1;
        end
        if (!b.is_last) return 1'b0;
        r.resp_kind = RESP_ADD;
        if (n_entries < ENTRIES) begin
          name_len[n_entries] = wr_pos;
          ident[n_entries] = b.command_id;
          r.add_ok = 1'b1;
          r.entry_index = n_entries[5:0];
          n_entries = n_entries + 7'd1;
        end
        wr_pos = '0;
        closed = 1'b0;
        return 1'b1;
      end
      REQ_QUERY: begin
        if (b.char_code == 8'h00) return 1'b0;
        q = to_lower(b.char_code);
        for (i = 0; i < n_entries; i++) begin
          if (!failed[i]) begin
            pos = scan_pos[i];
            len = name_len[i];
            while (pos < len && to_lower(name_mem[i][pos]) != q) pos++;
            if (pos >= len) begin
              failed[i] = 1'b1;
              scan_pos[i] = len[5:0];
            end else begin
              scan_pos[i] = 6'(pos + 1);
            end
          end
        end
        return 1'b0;
      end
      default: begin
        r.resp_kind = RESP_QUERY;
        r.best_id = BEST_NONE;
        for (i = 0; i < n_entries; i++) begin
          if (!failed[i]) begin
            if (!r.best_found) begin
              r.best_found = 1'b1;
              r.best_id = ident[i];
            end
            r.match_count = r.match_count + 7'd1;
          end
        end
        reset_scan();
        return 1'b1;
      end
    endcase
  endfunction

  task automatic push_beat(input logic [1:0] req, input logic [7:0] ch, input logic last,
                           input logic signed [31:0] id, input bit drain);
    pending_t p;
    p.beat.req_type   = req;
    p.beat.char_code  = ch;
    p.beat.is_last    = last;
    p.beat.command_id = id;
    p.drain           = drain;
    beats_to_send.push_back(p);
    if (!(req == REQ_QUERY && ch == 8'h00)) beat_count++;
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = 8'($urandom_range(1, 255));
      1: c = BOUNDARY_BYTES[8*$urandom_range(0, 3) +: 8];
      default: begin
        c = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) c = c - 8'h20;
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] rand_id();
    logic signed [31:0] v;
    case ($urandom_range(0, 19))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7FFF_FFFF;
      2: v = 32'sd0;
      3: v = -32'sd1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_name(input int len, input logic signed [31:0] id);
    logic [7:0] ch;
    int k;
    if (len == 0) push_beat(REQ_NAME, 8'h00, 1'b1, id, 1'b0);
    for (k = 0; k < len; k++) begin
      ch = pick_char();
      if (gen_cnt < ENTRIES && k < NAME_LEN) gen_name[gen_cnt][k] = ch;
      push_beat(REQ_NAME, ch, k == len - 1, (k == len - 1) ? id : $urandom, 1'b0);
    end
    if (gen_cnt < ENTRIES) begin
      gen_len[gen_cnt] = (len < NAME_LEN) ? len : NAME_LEN;
      gen_cnt++;
    end
  endtask

  // Send a random subsequence of a stored name with shuffled case, at times one random byte, then end.
  task automatic query_entry(input bit drain);
    int e;
    int k;
    logic [7:0] ch;
    if (gen_cnt != 0) begin
      e = $urandom_range(0, gen_cnt - 1);
      for (k = 0; k < gen_len[e]; k++) begin
        if ($urandom_range(0, 1)) begin
          ch = gen_name[e][k];
          if (((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)) &&
              $urandom_range(0, 1))
            ch = ch ^ 8'h20;
          push_beat(REQ_QUERY, ch, 1'($urandom), $urandom, 1'b0);
        end
      end
    end
    if ($urandom_range(0, 4) == 0) push_beat(REQ_QUERY, pick_char(), 1'b0, $urandom, 1'b0);
    push_beat(REQ_END, 8'($urandom), 1'($urandom), $urandom, drain);
  endtask

  // driver: hold a beat until taken, then wait a random gap before the next
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        if (predict_reply(in_data, new_reply)) replies_due.push_back(new_reply);
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (beats_to_send.size() != 0 &&
                     !(beats_to_send[0].drain && replies_due.size() != 0)) begin
          next_beat = beats_to_send.pop_front();
          in_data <= next_beat.beat;
          start <= 1'b1;
          idle_left = $urandom_range(0, 4);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed reply must match the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("reply with none pending: %p", out_data));
      end else begin
        oldest_reply = replies_due.pop_front();
        if (out_data.resp_kind !== oldest_reply.resp_kind)
          report_mismatch($sformatf("resp_kind %0d, want %0d",
                                    out_data.resp_kind, oldest_reply.resp_kind));
        if (out_data.add_ok !== oldest_reply.add_ok)
          report_mismatch($sformatf("add_ok %0d, want %0d",
                                    out_data.add_ok, oldest_reply.add_ok));
        if (out_data.entry_index !== oldest_reply.entry_index)
          report_mismatch($sformatf("entry_index %0d, want %0d",
                                    out_data.entry_index, oldest_reply.entry_index));
        if (out_data.match_count !== oldest_reply.match_count)
          report_mismatch($sformatf("match_count %0d, want %0d",
                                    out_data.match_count, oldest_reply.match_count));
        if (out_data.best_found !== oldest_reply.best_found)
          report_mismatch($sformatf("best_found %0d, want %0d",
                                    out_data.best_found, oldest_reply.best_found));
        if (out_data.best_id !== oldest_reply.best_id)
          report_mismatch($sformatf("best_id %0d, want %0d",
                                    out_data.best_id, oldest_reply.best_id));
      end
    end
  end

  initial begin
    int roll;
    int len;
    int k;
    bit full_done;
    full_done = 1'b0;

    // directed: empty table, extreme ids, empty name, zero bytes, case folding
    push_beat(REQ_END, 8'h00, 1'b0, 32'sd0, 1'b0);
    push_beat(REQ_NAME, 8'h41, 1'b0, $urandom, 1'b0);
    push_beat(REQ_NAME, 8'h62, 1'b1, 32'sh8000_0000, 1'b0);
    push_beat(REQ_NAME, 8'h00, 1'b1, 32'sh7FFF_FFFF, 1'b0);
    push_beat(REQ_NAME, 8'h78, 1'b0, 32'sd5, 1'b0);
    push_beat(REQ_NAME, 8'h00, 1'b0, 32'sd6, 1'b0);
    push_beat(REQ_NAME, 8'h79, 1'b1, -32'sd1, 1'b0);
    push_beat(REQ_QUERY, 8'h61, 1'b0, 32'sd0, 1'b0);
    push_beat(REQ_QUERY, 8'h00, 1'b1, 32'sd0, 1'b0);
    push_beat(REQ_QUERY, 8'h42, 1'b0, 32'sd0, 1'b0);
    push_beat(REQ_END, 8'hFF, 1'b1, -32'sd1, 1'b0);
    push_beat(REQ_END, 8'h00, 1'b0, 32'sd0, 1'b0);
    // a name beat in mid query abandons it
    push_beat(REQ_QUERY, 8'h58, 1'b0, 32'sd0, 1'b0);
    push_beat(REQ_NAME, 8'h51, 1'b0, 32'sd9, 1'b0);
    push_beat(REQ_END, 8'h00, 1'b0, 32'sd0, 1'b0);
    // clear drops the partial name
    push_beat(REQ_CLEAR, 8'hFF, 1'b1, -32'sd1, 1'b0);
    push_beat(REQ_END, 8'h00, 1'b0, 32'sd0, 1'b0);
    push_beat(REQ_NAME, 8'hFF, 1'b1, 32'sd0, 1'b0);
    push_beat(REQ_QUERY, 8'hFF, 1'b1, 32'sd0, 1'b0);
    push_beat(REQ_END, 8'h00, 1'b0, 32'sd0, 1'b0);
    // '@' and '`' sit just outside the folded range
    push_beat(REQ_NAME, 8'h40, 1'b1, 32'sd17, 1'b0);
    push_beat(REQ_QUERY, 8'h60, 1'b0, 32'sd0, 1'b0);
    push_beat(REQ_END, 8'h00, 1'b0, 32'sd0, 1'b0);
    push_beat(REQ_CLEAR, 8'h00, 1'b0, 32'sd0, 1'b0);
    gen_cnt = 0;

    // random: mostly adds and well-formed queries, some noise
    query_entry(1'b1);
    while (beat_count < DIRECTED + RANDOM_BEATS) begin
      if (!full_done && beat_count > DIRECTED + 80) begin
        // fill the table, then overflow it
        push_beat(REQ_CLEAR, 8'($urandom), 1'($urandom), $urandom, 1'b1);
        gen_cnt = 0;
        for (k = 0; k < ENTRIES; k++) add_name($urandom_range(1, 2), rand_id());
        add_name(3, rand_id());
        push_beat(REQ_END, 8'($urandom), 1'($urandom), $urandom, 1'b0);
        query_entry(1'b0);
        query_entry(1'b0);
        add_name(0, rand_id());
        push_beat(REQ_CLEAR, 8'($urandom), 1'($urandom), $urandom, 1'b1);
        gen_cnt = 0;
        full_done = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        case ($urandom_range(0, 19))
          0: len = 0;
          1, 2: len = $urandom_range(36, 45);
          default: len = $urandom_range(1, 8);
        endcase
        add_name(len, rand_id());
      end else if (roll < 80) begin
        query_entry(roll < 46);
      end else if (roll < 88) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++)
          push_beat(REQ_QUERY, 8'($urandom), 1'($urandom), $urandom, 1'b0);
        push_beat(REQ_END, 8'($urandom), 1'($urandom), $urandom, 1'b0);
      end else if (roll < 93) begin
        case ($urandom_range(0, 1))
          0: push_beat(REQ_END, 8'($urandom), 1'($urandom), $urandom, 1'b0);
          default: push_beat(REQ_QUERY, 8'h00, 1'($urandom), $urandom, 1'b0);
        endcase
      end else if (roll < 96) begin
        // broken: partial name, then a query and end, then a clear that drops the name
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) push_beat(REQ_NAME, pick_char(), 1'b0, $urandom, 1'b0);
        push_beat(REQ_QUERY, pick_char(), 1'b0, $urandom, 1'b0);
        push_beat(REQ_END, 8'($urandom), 1'($urandom), $urandom, 1'b0);
        push_beat(REQ_CLEAR, 8'($urandom), 1'($urandom), $urandom, 1'b0);
        gen_cnt = 0;
      end else begin
        push_beat(REQ_CLEAR, 8'($urandom), 1'($urandom), $urandom, 1'b0);
        gen_cnt = 0;
      end
    end
    push_beat(REQ_END, 8'($urandom), 1'($urandom), $urandom, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_to_send.size() != 0 || start || replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (replies_due.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TIMEOUT");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[fuzzy_subsequence_command_match.f]
+incdir+design
design/fscm_pkg.sv
design/fuzzy_subsequence_command_match.sv
verif/fuzzy_subsequence_command_match_tb.sv
